// ===== rtl/fplt_pkg.sv =====
`default_nettype none
package fplt_pkg;

  localparam int LEASE_SLOTS = 16;
  localparam int SEQ_SLOTS = 64;
  localparam int LEASE_AW = $clog2(LEASE_SLOTS);
  localparam int SEQ_AW = $clog2(SEQ_SLOTS);
  localparam int CNT_W = $clog2(LEASE_SLOTS + 1);
  localparam int KEY_W = 24;
  localparam int SEQ_W = 64;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [2:0] TR_NONE = 3'd0;
  localparam logic [2:0] TR_ACQUIRED = 3'd1;
  localparam logic [2:0] TR_UPDATED = 3'd2;
  localparam logic [2:0] TR_FENCED = 3'd3;
  localparam logic [2:0] TR_RELEASED = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] owner_id;
    logic [15:0] txn_id;
    logic [7:0] reason_code;
    logic [63:0] cmd_seq;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    logic changed;
    logic [1:0] status;
    logic [63:0] applied_seq;
    logic [31:0] gen_count;
    logic paused;
    logic [4:0] lease_count;
    logic [2:0] transition_kind;
  } rsp_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SSCAN = 7'b0000010,
    S_SDEC = 7'b0000100,
    S_LSCAN = 7'b0001000,
    S_LDEC = 7'b0010000,
    S_APPLY = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/fenced_pause_lease_table.sv =====
`default_nettype none
// Pause-lease table with per-key sequence fencing. Raise start with a word on
// cmd while busy is low; exactly one result word appears on rsp with done high
// for one cycle, and the receiver cannot stall it. A malformed command goes
// straight to the done state. Otherwise the sequence memory is scanned one
// entry per cycle, then the read pipeline drains; a stale command or a full
// sequence table then answers. Any other command goes on to scan the lease
// memory and to read the matched lease before its result appears. Busy stays
// high until the cycle of the result, and the next word can be accepted at
// the edge that ends it. Valid bits are flip-flops and clear at reset, so no
// clearing pass is needed.
module fenced_pause_lease_table (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire fplt_pkg::cmd_t cmd,
  output logic busy,
  output logic done,
  output fplt_pkg::rsp_t rsp
);
  localparam int SAW = fplt_pkg::SEQ_AW;
  localparam int LAW = fplt_pkg::LEASE_AW;
  localparam int KW = fplt_pkg::KEY_W;
  localparam int CW = fplt_pkg::CNT_W;

  fplt_pkg::state_t state;
  fplt_pkg::cmd_t c;
  logic [KW-1:0] key;

  logic [SAW:0] sidx;
  logic [SAW-1:0] s_rd;
  logic s_rv;
  logic [SAW-1:0] s_rd_q;
  logic s_hit, s_free_f;
  logic [SAW-1:0] s_slot, s_free;
  logic [fplt_pkg::SEQ_SLOTS-1:0] seq_valid;

  logic [LAW:0] lidx;
  logic [LAW-1:0] l_rd_q;
  logic l_rv;
  logic l_hit, l_free_f;
  logic [LAW-1:0] l_slot, l_free;
  logic [fplt_pkg::LEASE_SLOTS-1:0] lease_valid;

  logic [31:0] generation;
  logic [2:0] last_transition;
  logic [CW-1:0] held_count;

  logic res_accepted;
  logic res_changed;
  logic [1:0] res_status;
  logic [63:0] res_seq;

  // Memories.
  logic sk_we, sl_we, lk_we, lr_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [KW-1:0] sk_rdata, lk_rdata;
  logic [63:0] sl_rdata;
  logic [7:0] lr_rdata, lr_wdata;

  fplt_ram #(.WIDTH(KW), .DEPTH(fplt_pkg::SEQ_SLOTS)) u_seq_key (
    .clk(clk), .we(sk_we), .waddr(s_waddr), .wdata(key), .raddr(s_raddr),
    .rdata(sk_rdata));
  fplt_ram #(.WIDTH(64), .DEPTH(fplt_pkg::SEQ_SLOTS)) u_seq_last (
    .clk(clk), .we(sl_we), .waddr(s_waddr), .wdata(c.cmd_seq), .raddr(s_raddr),
    .rdata(sl_rdata));
  fplt_ram #(.WIDTH(KW), .DEPTH(fplt_pkg::LEASE_SLOTS)) u_lease_key (
    .clk(clk), .we(lk_we), .waddr(l_waddr), .wdata(key), .raddr(l_raddr),
    .rdata(lk_rdata));
  fplt_ram #(.WIDTH(8), .DEPTH(fplt_pkg::LEASE_SLOTS)) u_lease_reason (
    .clk(clk), .we(lr_we), .waddr(l_waddr), .wdata(lr_wdata), .raddr(l_raddr),
    .rdata(lr_rdata));

  assign key = {c.owner_id, c.txn_id};
  assign busy = (state != fplt_pkg::S_IDLE);
  assign s_rd = sidx[SAW-1:0];

  // Once the scan has issued its last read, the read address moves to the
  // matched entry so that its data is ready in the decision state.
  assign s_raddr = (state == fplt_pkg::S_SSCAN &&
                    sidx != (SAW+1)'(fplt_pkg::SEQ_SLOTS)) ? s_rd : s_slot;
  assign l_raddr = (state == fplt_pkg::S_LSCAN) ? lidx[LAW-1:0] : l_slot;

  logic seq_new;
  logic [SAW-1:0] s_target;
  assign s_target = s_hit ? s_slot : s_free;
  assign s_waddr = s_target;
  assign seq_new = !s_hit;

  logic is_acq, stale, sfull;
  assign is_acq = (c.opcode == fplt_pkg::OP_ACQUIRE);
  assign stale = s_hit && (c.cmd_seq <= sl_rdata);
  assign sfull = !s_hit && !s_free_f;

  always_comb begin
    sk_we = 1'b0;
    sl_we = 1'b0;
    if (state == fplt_pkg::S_SDEC && !stale && !sfull) begin
      sk_we = seq_new;
      sl_we = 1'b1;
    end
  end

  logic acq_new;
  assign acq_new = is_acq && !l_hit && l_free_f && (c.reason_code != 8'd0);
  assign l_waddr = l_hit ? l_slot : l_free;
  assign lr_wdata = c.reason_code;
  always_comb begin
    lk_we = 1'b0;
    lr_we = 1'b0;
    if (state == fplt_pkg::S_LDEC && is_acq && c.reason_code != 8'd0) begin
      lk_we = acq_new;
      lr_we = acq_new || (l_hit && lr_rdata != c.reason_code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fplt_pkg::S_IDLE;
      done <= 1'b0;
      seq_valid <= '0;
      lease_valid <= '0;
      generation <= '0;
      last_transition <= fplt_pkg::TR_NONE;
      held_count <= '0;
      s_rv <= 1'b0;
      l_rv <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        fplt_pkg::S_IDLE: begin
          if (start) begin
            c <= cmd;
            sidx <= '0;
            s_rv <= 1'b0;
            s_hit <= 1'b0;
            s_free_f <= 1'b0;
            if (cmd.owner_id == 8'd0 || cmd.txn_id == 16'd0 || cmd.opcode[1]
                || cmd.cmd_seq == 64'd0) begin
              res_accepted <= 1'b0;
              res_changed <= 1'b0;
              res_status <= fplt_pkg::ST_INVALID;
              res_seq <= '0;
              state <= fplt_pkg::S_DONE;
            end else begin
              state <= fplt_pkg::S_SSCAN;
            end
          end
        end
        fplt_pkg::S_SSCAN: begin
          // Data read in the previous cycle belongs to entry s_rd_q.
          s_rv <= (sidx < (SAW+1)'(fplt_pkg::SEQ_SLOTS));
          s_rd_q <= s_rd;
          if (s_rv) begin
            if (seq_valid[s_rd_q]) begin
              if (!s_hit && sk_rdata == key) begin
                s_hit <= 1'b1;
                s_slot <= s_rd_q;
              end
            end else if (!s_free_f) begin
              s_free_f <= 1'b1;
              s_free <= s_rd_q;
            end
          end
          if (sidx == (SAW+1)'(fplt_pkg::SEQ_SLOTS) && !s_rv) begin
            state <= fplt_pkg::S_SDEC;
          end else if (sidx != (SAW+1)'(fplt_pkg::SEQ_SLOTS)) begin
            sidx <= sidx + (SAW+1)'(1);
          end
        end
        fplt_pkg::S_SDEC: begin
          // sl_rdata holds the recorded sequence of the matched entry.
          res_accepted <= 1'b0;
          res_changed <= 1'b0;
          lidx <= '0;
          l_rv <= 1'b0;
          l_hit <= 1'b0;
          l_free_f <= 1'b0;
          if (stale) begin
            res_status <= fplt_pkg::ST_STALE;
            res_seq <= sl_rdata;
            state <= fplt_pkg::S_DONE;
          end else if (sfull) begin
            res_status <= fplt_pkg::ST_FULL;
            res_seq <= '0;
            state <= fplt_pkg::S_DONE;
          end else begin
            if (seq_new) begin
              seq_valid[s_target] <= 1'b1;
            end
            res_seq <= c.cmd_seq;
            state <= fplt_pkg::S_LSCAN;
          end
        end
        fplt_pkg::S_LSCAN: begin
          l_rv <= (lidx < (LAW+1)'(fplt_pkg::LEASE_SLOTS));
          l_rd_q <= lidx[LAW-1:0];
          if (l_rv) begin
            if (lease_valid[l_rd_q]) begin
              if (!l_hit && lk_rdata == key) begin
                l_hit <= 1'b1;
                l_slot <= l_rd_q;
              end
            end else if (!l_free_f) begin
              l_free_f <= 1'b1;
              l_free <= l_rd_q;
            end
          end
          if (lidx == (LAW+1)'(fplt_pkg::LEASE_SLOTS) && !l_rv) begin
            state <= fplt_pkg::S_APPLY;
          end else if (lidx != (LAW+1)'(fplt_pkg::LEASE_SLOTS)) begin
            lidx <= lidx + (LAW+1)'(1);
          end
        end
        fplt_pkg::S_APPLY: begin
          // A wait state so lr_rdata reflects the matched lease in S_LDEC.
          state <= fplt_pkg::S_LDEC;
        end
        fplt_pkg::S_LDEC: begin
          state <= fplt_pkg::S_DONE;
          if (is_acq) begin
            if (c.reason_code == 8'd0) begin
              res_status <= fplt_pkg::ST_INVALID;
            end else if (l_hit) begin
              res_status <= fplt_pkg::ST_OK;
              res_accepted <= 1'b1;
              if (lr_rdata != c.reason_code) begin
                res_changed <= 1'b1;
                generation <= generation + 32'd1;
                last_transition <= fplt_pkg::TR_UPDATED;
              end
            end else if (!l_free_f) begin
              res_status <= fplt_pkg::ST_FULL;
            end else begin
              res_status <= fplt_pkg::ST_OK;
              res_accepted <= 1'b1;
              res_changed <= 1'b1;
              lease_valid[l_free] <= 1'b1;
              held_count <= held_count + CW'(1);
              generation <= generation + 32'd1;
              last_transition <= fplt_pkg::TR_ACQUIRED;
            end
          end else begin
            res_status <= fplt_pkg::ST_OK;
            res_accepted <= 1'b1;
            res_changed <= 1'b1;
            generation <= generation + 32'd1;
            if (l_hit) begin
              lease_valid[l_slot] <= 1'b0;
              held_count <= held_count - CW'(1);
              last_transition <= fplt_pkg::TR_RELEASED;
            end else begin
              last_transition <= fplt_pkg::TR_FENCED;
            end
          end
        end
        fplt_pkg::S_DONE: begin
          done <= 1'b1;
          state <= fplt_pkg::S_IDLE;
        end
        default: state <= fplt_pkg::S_IDLE;
      endcase
    end
  end

  assign rsp.accepted = res_accepted;
  assign rsp.changed = res_changed;
  assign rsp.status = res_status;
  assign rsp.applied_seq = res_seq;
  assign rsp.gen_count = generation;
  assign rsp.paused = (held_count != '0);
  assign rsp.lease_count = 5'(held_count);
  assign rsp.transition_kind = last_transition;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    held_count == CW'($countones(lease_valid)))
    else $error("held count disagrees with lease valid bits");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    generation != $past(generation) |-> $past(state) == fplt_pkg::S_LDEC)
    else $error("generation changed outside decision");
`endif
endmodule
`default_nettype wire

// ===== rtl/fplt_ram.sv =====
`default_nettype none
module fplt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== test/fenced_pause_lease_table_tb.sv =====
module fenced_pause_lease_table_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam int POOL_KEYS = 24;
  localparam int KEY_W = fplt_pkg::KEY_W;
  localparam int SEQ_W = fplt_pkg::SEQ_W;
  localparam int SEQ_SLOTS = fplt_pkg::SEQ_SLOTS;
  localparam int LEASE_SLOTS = fplt_pkg::LEASE_SLOTS;
  localparam logic [1:0] ACQ = fplt_pkg::OP_ACQUIRE;
  localparam logic [1:0] REL = fplt_pkg::OP_RELEASE;
  // Opcodes the block does not support.
  localparam logic [1:0] OP_SPARE_A = 2'd2;
  localparam logic [1:0] OP_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  fplt_pkg::cmd_t cmd = '0;
  logic busy;
  logic done;
  fplt_pkg::rsp_t rsp;

  fenced_pause_lease_table u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block's tables.
  logic [KEY_W-1:0] fence_key [SEQ_SLOTS];
  logic [SEQ_W-1:0] fence_last [SEQ_SLOTS];
  logic fence_used [SEQ_SLOTS];
  logic [KEY_W-1:0] hold_key [LEASE_SLOTS];
  logic [7:0] hold_reason [LEASE_SLOTS];
  logic hold_used [LEASE_SLOTS];
  logic [31:0] gen_m;
  logic [2:0] trans_m;
  logic [4:0] held_m;

  fplt_pkg::rsp_t pending_rsp[$];
  int errors = 0;
  int cycles = 0;

  function automatic fplt_pkg::rsp_t status_word(logic acc, logic chg, logic [1:0] st,
                                                 logic [63:0] seq);
    fplt_pkg::rsp_t r;
    r.accepted = acc;
    r.changed = chg;
    r.status = st;
    r.applied_seq = seq;
    r.gen_count = gen_m;
    r.paused = (held_m != 5'd0);
    r.lease_count = held_m;
    r.transition_kind = trans_m;
    return r;
  endfunction

  function automatic fplt_pkg::rsp_t lease_decision(fplt_pkg::cmd_t c);
    logic [KEY_W-1:0] key;
    int sslot;
    int sfree;
    int lslot;
    int lfree;
    logic chg;
    key = {c.owner_id, c.txn_id};
    sslot = -1;
    sfree = -1;
    lslot = -1;
    lfree = -1;
    if (c.owner_id == 8'd0 || c.txn_id == 16'd0 || (c.opcode != ACQ &&
        c.opcode != REL) || c.cmd_seq == 64'd0)
      return status_word(1'b0, 1'b0, fplt_pkg::ST_INVALID, '0);
    for (int i = 0; i < SEQ_SLOTS; i++) begin
      if (fence_used[i]) begin
        if (sslot < 0 && fence_key[i] == key) sslot = i;
      end else if (sfree < 0) begin
        sfree = i;
      end
    end
    if (sslot >= 0 && c.cmd_seq <= fence_last[sslot])
      return status_word(1'b0, 1'b0, fplt_pkg::ST_STALE, fence_last[sslot]);
    if (sslot < 0) begin
      if (sfree < 0) return status_word(1'b0, 1'b0, fplt_pkg::ST_FULL, '0);
      sslot = sfree;
      fence_used[sslot] = 1'b1;
      fence_key[sslot] = key;
    end
    fence_last[sslot] = c.cmd_seq;
    for (int i = 0; i < LEASE_SLOTS; i++) begin
      if (hold_used[i]) begin
        if (lslot < 0 && hold_key[i] == key) lslot = i;
      end else if (lfree < 0) begin
        lfree = i;
      end
    end
    if (c.opcode == ACQ) begin
      if (c.reason_code == 8'd0)
        return status_word(1'b0, 1'b0, fplt_pkg::ST_INVALID, c.cmd_seq);
      if (lslot >= 0) begin
        chg = (hold_reason[lslot] != c.reason_code);
        if (chg) begin
          hold_reason[lslot] = c.reason_code;
          gen_m = gen_m + 32'd1;
          trans_m = fplt_pkg::TR_UPDATED;
        end
        return status_word(1'b1, chg, fplt_pkg::ST_OK, c.cmd_seq);
      end
      if (lfree < 0) return status_word(1'b0, 1'b0, fplt_pkg::ST_FULL, c.cmd_seq);
      hold_used[lfree] = 1'b1;
      hold_key[lfree] = key;
      hold_reason[lfree] = c.reason_code;
      held_m = held_m + 5'd1;
      gen_m = gen_m + 32'd1;
      trans_m = fplt_pkg::TR_ACQUIRED;
      return status_word(1'b1, 1'b1, fplt_pkg::ST_OK, c.cmd_seq);
    end
    if (lslot < 0) begin
      trans_m = fplt_pkg::TR_FENCED;
    end else begin
      hold_used[lslot] = 1'b0;
      held_m = held_m - 5'd1;
      trans_m = fplt_pkg::TR_RELEASED;
    end
    gen_m = gen_m + 32'd1;
    return status_word(1'b1, 1'b1, fplt_pkg::ST_OK, c.cmd_seq);
  endfunction

  always @(posedge clk) begin
    fplt_pkg::rsp_t exp_r;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %p", $realtime, rsp);
      end else begin
        exp_r = pending_rsp.pop_front();
        if (exp_r !== rsp) begin
          errors++;
          $display("%0t: result mismatch, expected %p, got %p", $realtime, exp_r, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(fplt_pkg::cmd_t c, logic has_fixed, fplt_pkg::rsp_t fixed);
    int gap;
    fplt_pkg::rsp_t pred;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pred = lease_decision(c);
    pending_rsp.insert(pending_rsp.size(), has_fixed ? fixed : pred);
    @(negedge clk);
  endtask

  function automatic fplt_pkg::cmd_t mk(logic [1:0] op, logic [7:0] own, logic [15:0] txn,
                                        logic [7:0] rsn, logic [63:0] seq);
    fplt_pkg::cmd_t c;
    c.opcode = op;
    c.owner_id = own;
    c.txn_id = txn;
    c.reason_code = rsn;
    c.cmd_seq = seq;
    return c;
  endfunction

  typedef struct {
    fplt_pkg::cmd_t c;
    logic fixed;
  } stim_row_t;

  stim_row_t directed[$];
  logic [23:0] pool_key [POOL_KEYS];
  logic [63:0] pool_seq [POOL_KEYS];

  task automatic add_row(fplt_pkg::cmd_t c, logic fixed);
    stim_row_t row;
    row.c = c;
    row.fixed = fixed;
    directed.insert(directed.size(), row);
  endtask

  initial begin
    fplt_pkg::rsp_t invalid_r;
    fplt_pkg::cmd_t c;
    logic [127:0] noise;
    int k;
    int pick;
    for (int i = 0; i < SEQ_SLOTS; i++) fence_used[i] = 1'b0;
    for (int i = 0; i < LEASE_SLOTS; i++) hold_used[i] = 1'b0;
    gen_m = '0;
    trans_m = fplt_pkg::TR_NONE;
    held_m = '0;
    invalid_r = '0;
    invalid_r.status = fplt_pkg::ST_INVALID;

    // Malformed words first, while the state is still at reset.
    add_row(mk(ACQ, 8'd0, 16'd5, 8'd1, 64'd1), 1'b1);
    add_row(mk(ACQ, 8'd5, 16'd0, 8'd1, 64'd1), 1'b1);
    add_row(mk(OP_SPARE_A, 8'd5, 16'd5, 8'd1, 64'd1), 1'b1);
    add_row(mk(OP_SPARE_B, 8'd5, 16'd5, 8'd1, 64'd1), 1'b1);
    add_row(mk(REL, 8'd5, 16'd5, 8'd1, 64'd0), 1'b1);
    add_row(mk(ACQ, 8'hff, 16'hffff, 8'hff, 64'hffff_ffff_ffff_fffe), 1'b0);
    add_row(mk(ACQ, 8'hff, 16'hffff, 8'hff, 64'hffff_ffff_ffff_fffe), 1'b0);
    add_row(mk(ACQ, 8'hff, 16'hffff, 8'hff, 64'hffff_ffff_ffff_ffff), 1'b0);
    add_row(mk(ACQ, 8'd1, 16'd1, 8'd7, 64'd1), 1'b0);
    add_row(mk(ACQ, 8'd1, 16'd1, 8'd7, 64'd2), 1'b0);
    add_row(mk(ACQ, 8'd1, 16'd1, 8'd9, 64'd3), 1'b0);
    add_row(mk(ACQ, 8'd1, 16'd1, 8'd0, 64'd4), 1'b0);
    add_row(mk(REL, 8'd1, 16'd1, 8'd0, 64'd5), 1'b0);
    add_row(mk(REL, 8'd1, 16'd1, 8'd0, 64'd6), 1'b0);
    add_row(mk(REL, 8'd1, 16'd1, 8'd0, 64'd6), 1'b0);
    add_row(mk(REL, 8'd2, 16'h8000, 8'd0, 64'h8000_0000_0000_0000), 1'b0);
    add_row(mk(ACQ, 8'h80, 16'd1, 8'd1, 64'd1), 1'b0);

    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_key[i] = {8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535))};
      pool_seq[i] = 64'($urandom_range(1, 100));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) issue(directed[i].c, directed[i].fixed, invalid_r);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // Noise: any field may be malformed.
        noise = {$urandom, $urandom, $urandom, $urandom};
        c = noise[$bits(fplt_pkg::cmd_t)-1:0];
        if ($urandom_range(0, 1)) c.owner_id = '0;
        else if ($urandom_range(0, 1)) c.txn_id = '0;
        else if ($urandom_range(0, 1)) c.cmd_seq = '0;
      end else if (pick < 16) begin
        // A fresh key, which slowly fills the sequence table.
        c = mk(2'($urandom_range(0, 1)), 8'($urandom_range(1, 255)),
               16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
               {$urandom, $urandom});
      end else begin
        k = $urandom_range(0, POOL_KEYS - 1);
        c.opcode = ($urandom_range(0, 99) < 60) ? ACQ : REL;
        {c.owner_id, c.txn_id} = pool_key[k];
        c.reason_code = ($urandom_range(0, 19) == 0) ? 8'd0 :
                        ($urandom_range(0, 1) ? 8'($urandom_range(1, 3)) : 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          c.cmd_seq = pool_seq[k] - 64'($urandom_range(0, 2));
        end else if (pick < 9) begin
          c.cmd_seq = {$urandom, $urandom};
        end else begin
          c.cmd_seq = pool_seq[k] + 64'($urandom_range(1, 4));
        end
        if (c.cmd_seq > pool_seq[k]) pool_seq[k] = c.cmd_seq;
      end
      issue(c, 1'b0, invalid_r);
    end
    start <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
